/* rtl/stnl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Night lamp package
// Shared sizes, codes, stage item types and a helper function for the
// sound-triggered night lamp.
// ----------------------------------------------------------------------------
package stnl_pkg;

   // sizing
   localparam int WINDOW_DEPTH  = 8;
   localparam int HISTORY_DEPTH = 5;
   localparam int SAMPLE_BITS   = 14;

   localparam int PHASE_W = $clog2(WINDOW_DEPTH);
   localparam int WSUM_W  = SAMPLE_BITS + PHASE_W;
   localparam int HSUM_W  = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
   // both sides of the loudness compare fit in this width
   localparam int CMP_W   = HSUM_W + 4;

   // exact floor(wsum / WINDOW_DEPTH) as a multiply by a rounded-up reciprocal
   localparam int MEAN_SHIFT = WSUM_W + PHASE_W;
   localparam int RECIP_W    = WSUM_W + 1;
   localparam int PROD_W     = WSUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

   // 1.10 ratio in integers: mean * 10 * depth > 11 * history sum
   localparam logic [CMP_W-1:0] MEAN_GAIN = CMP_W'(10 * HISTORY_DEPTH);
   localparam logic [CMP_W-1:0] HIST_GAIN = CMP_W'(11);

   // configuration
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_DARK_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ON_DURATION    = 1'b1;
   localparam logic [CSR_DATA_W-1:0] DARK_THRESHOLD_RST = 16'd17;
   localparam logic [CSR_DATA_W-1:0] ON_DURATION_RST    = 16'd24;

   // lamp count and masks
   localparam logic [1:0] LAMP_COUNT_ONE = 2'd1;
   localparam logic [1:0] LAMP_COUNT_TWO = 2'd2;
   localparam logic [1:0] LAMP_COUNT_ALL = 2'd3;
   localparam logic [2:0] MASK_ALL    = 3'b111;
   localparam logic [2:0] MASK_FIRST  = 3'b001;
   localparam logic [2:0] MASK_SECOND = 3'b010;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_POWER = 2'd1,
      CMD_COUNT = 2'd2,
      CMD_IDLE  = 2'd3
   } cmd_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [WSUM_W-1:0]      wsum_type;
   typedef logic [HSUM_W-1:0]      hsum_type;
   typedef logic [CMP_W-1:0]       cmp_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [1:0]             lamp_count_type;
   typedef logic [2:0]             lamp_mask_type;

   // item after the window stage
   typedef struct packed {
      cmd_type  cmd;
      logic     dark;
      logic     wrap;
      wsum_type wsum;
   } s1_item_type;

   // item after the mean stage
   typedef struct packed {
      cmd_type    cmd;
      logic       dark;
      logic       wrap;
      sample_type mean;
   } s2_item_type;

   // item after the history stage, into lamp control
   typedef struct packed {
      cmd_type  cmd;
      logic     dark;
      cmp_type  mean_scaled;
      hsum_type hsum;
   } s3_item_type;

   function automatic lamp_mask_type select_mask(input lamp_count_type count);
      lamp_mask_type mask;
      case (count)
         LAMP_COUNT_TWO: mask = MASK_FIRST;
         LAMP_COUNT_ONE: mask = MASK_SECOND;
         default:        mask = MASK_ALL;
      endcase
      return mask;
   endfunction

endpackage

/* rtl/stnl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample cell
// One link of a sample shift chain: holds a sample and passes it on to the
// next cell whenever the chain shifts.
// ----------------------------------------------------------------------------
module stnl_cell
   import stnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  sample_type data_in,
   output sample_type data_out
);

   sample_type data_ff;
   sample_type data_in_mux;

   // take the neighbour's sample on a shift
   assign data_in_mux = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in_mux;
      end
   end

   assign data_out = data_ff;

endmodule

/* rtl/stnl_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample window
// Chain of cells holding the last WINDOW_DEPTH microphone samples, with a
// running sum and the phase counter that marks each full window.
// ----------------------------------------------------------------------------
module stnl_window
   import stnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  sample_type mic_sample,
   output wsum_type   wsum_next,
   output logic       wrap
);

   sample_type           chain [WINDOW_DEPTH];
   wsum_type             wsum_ff;
   wsum_type             wsum_in;
   logic [PHASE_W-1:0]   phase_ff;
   logic [PHASE_W-1:0]   phase_in;

   // cells: newest at the head, oldest drops out of the tail
   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         stnl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .data_in  (mic_sample),
            .data_out (chain[k])
         );
      end else begin : g_body
         stnl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .data_in  (chain[k-1]),
            .data_out (chain[k])
         );
      end
   end

   // running sum: add the new sample, drop the evicted one
   assign wsum_next = wsum_ff + WSUM_W'(mic_sample) - WSUM_W'(chain[WINDOW_DEPTH-1]);
   assign wsum_in   = shift_en ? wsum_next : wsum_ff;

   // phase: last sample of a window closes a second
   assign wrap     = (phase_ff == PHASE_W'(WINDOW_DEPTH - 1));
   assign phase_in = !shift_en ? phase_ff :
                     (wrap ? '0 : phase_ff + PHASE_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff  <= '0;
         phase_ff <= '0;
      end else begin
         wsum_ff  <= wsum_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/stnl_history.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second history
// Chain of cells holding the last HISTORY_DEPTH per-second means, with a
// running sum of them.
// ----------------------------------------------------------------------------
module stnl_history
   import stnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  sample_type mean_in,
   output hsum_type   hsum_now
);

   sample_type chain [HISTORY_DEPTH];
   hsum_type   hsum_ff;
   hsum_type   hsum_next;

   for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         stnl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .data_in  (mean_in),
            .data_out (chain[k])
         );
      end else begin : g_body
         stnl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .data_in  (chain[k-1]),
            .data_out (chain[k])
         );
      end
   end

   // running sum after this item's shift, if any
   assign hsum_next = hsum_ff + HSUM_W'(mean_in) - HSUM_W'(chain[HISTORY_DEPTH-1]);
   assign hsum_now  = shift_en ? hsum_next : hsum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff <= '0;
      end else begin
         hsum_ff <= hsum_now;
      end
   end

endmodule

/* rtl/stnl_lamp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp control
// Lamp on/off state, switch-off countdown and lamp count; loads the result
// register with the lamp outputs for each item.
// ----------------------------------------------------------------------------
module stnl_lamp_ctrl
   import stnl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load_en,
   input  s3_item_type   item,
   input  csr_data_type  on_duration,
   output lamp_mask_type lamp_drive,
   output logic          lamp_is_on,
   output lamp_mask_type lamp_select
);

   logic           light_on_ff,  light_on_in;
   csr_data_type   ticks_ff,     ticks_in;
   lamp_count_type count_ff,     count_in;
   lamp_mask_type  drive_ff,     drive_in;
   logic           is_on_ff;
   lamp_mask_type  select_ff,    select_in;
   cmp_type        hist_scaled;
   logic           loud;

   // loudness test against 1.10 of the history mean
   assign hist_scaled = CMP_W'(item.hsum) * HIST_GAIN;
   assign loud        = item.mean_scaled > hist_scaled;

   // next lamp state
   always_comb begin
      light_on_in = light_on_ff;
      ticks_in    = ticks_ff;
      count_in    = count_ff;
      case (item.cmd)
         CMD_TICK: begin
            if (light_on_ff) begin
               if (ticks_ff <= CSR_DATA_W'(1)) begin
                  light_on_in = 1'b0;
                  ticks_in    = '0;
               end else begin
                  ticks_in = ticks_ff - CSR_DATA_W'(1);
               end
            end else if (item.dark && loud) begin
               light_on_in = 1'b1;
               ticks_in    = on_duration;
            end
         end
         CMD_POWER: begin
            if (light_on_ff) begin
               light_on_in = 1'b0;
               ticks_in    = '0;
            end else begin
               light_on_in = 1'b1;
               ticks_in    = on_duration;
            end
         end
         CMD_COUNT: begin
            count_in = (count_ff >= LAMP_COUNT_ALL) ? LAMP_COUNT_ONE
                                                   : count_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // outputs follow the new state
   assign select_in = select_mask(count_in);
   assign drive_in  = light_on_in ? select_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_on_ff <= 1'b0;
         ticks_ff    <= '0;
         count_ff    <= LAMP_COUNT_ALL;
      end else if (load_en) begin
         light_on_ff <= light_on_in;
         ticks_ff    <= ticks_in;
         count_ff    <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_en) begin
         drive_ff  <= drive_in;
         is_on_ff  <= light_on_in;
         select_ff <= select_in;
      end
   end

   assign lamp_drive  = drive_ff;
   assign lamp_is_on  = is_on_ff;
   assign lamp_select = select_ff;

endmodule

/* rtl/sound_triggered_night_lamp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound-triggered night lamp
// Keeps a microphone window and a history of per-second means in chains of
// sample cells; switches the lamp on at night on a loud window, off after a
// tick countdown, and handles the power and lamp-count buttons.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------
// req     | in        | req_valid/req_stall | req_cmd, req_mic_sample,
//         |           |                     | req_lux_level
// rsp     | out       | rsp_valid/rsp_stall | rsp_lamp_drive, rsp_lamp_is_on,
//         |           |                     | rsp_lamp_select
// csr     | in        | csr_write_en        | csr_index, csr_write_data
//
// One item per cycle sustained while rsp_stall is low; four register stages
// (window, mean multiply, history, lamp control/result register), the first
// loaded at the accepting edge.
// On reset, cells, sums and lamp state clear and registers take their
// defaults. rsp_stall holds the result register; earlier stages keep filling
// and req_stall rises only once all four stages hold an item.
// ----------------------------------------------------------------------------
module sound_triggered_night_lamp_unit
   import stnl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // item input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [13:0]          req_mic_sample,
   input  logic [15:0]          req_lux_level,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_lamp_drive,
   output logic                 rsp_lamp_is_on,
   output logic [2:0]           rsp_lamp_select,
   // configuration
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_write_data
);

   csr_data_type dark_threshold_ff;
   csr_data_type on_duration_ff;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;
   logic accept, mv1, mv2, mv3;

   s1_item_type s1_ff, s1_in;
   s2_item_type s2_ff, s2_in;
   s3_item_type s3_ff, s3_in;

   cmd_type             req_cmd_code;
   wsum_type            win_wsum_next;
   logic                win_wrap;
   logic                hist_shift;
   hsum_type            hist_hsum;
   logic [PROD_W-1:0]   mean_prod;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff <= DARK_THRESHOLD_RST;
         on_duration_ff    <= ON_DURATION_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_DARK_THRESHOLD: dark_threshold_ff <= csr_write_data;
            REG_ON_DURATION:    on_duration_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pipeline flow: a stage takes a new item when empty or moving on
   assign rdy4 = !s4_valid_ff || !rsp_stall;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign accept = req_valid && rdy1;
   assign mv1    = s1_valid_ff && rdy2;
   assign mv2    = s2_valid_ff && rdy3;
   assign mv3    = s3_valid_ff && rdy4;

   assign s1_valid_in = accept || (s1_valid_ff && !mv1);
   assign s2_valid_in = mv1    || (s2_valid_ff && !mv2);
   assign s3_valid_in = mv2    || (s3_valid_ff && !mv3);
   assign s4_valid_in = mv3    || (s4_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = s4_valid_ff;

   // stage 1: sample window
   assign req_cmd_code = cmd_type'(req_cmd);

   stnl_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (accept && (req_cmd_code == CMD_TICK)),
      .mic_sample (req_mic_sample),
      .wsum_next  (win_wsum_next),
      .wrap       (win_wrap)
   );

   assign s1_in.cmd  = req_cmd_code;
   assign s1_in.dark = req_lux_level < dark_threshold_ff;
   assign s1_in.wrap = win_wrap;
   assign s1_in.wsum = win_wsum_next;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: window mean by reciprocal multiply
   assign mean_prod  = PROD_W'(s1_ff.wsum) * PROD_W'(MEAN_RECIP);
   assign s2_in.cmd  = s1_ff.cmd;
   assign s2_in.dark = s1_ff.dark;
   assign s2_in.wrap = s1_ff.wrap;
   assign s2_in.mean = mean_prod[MEAN_SHIFT +: SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: history of per-second means
   assign hist_shift = mv2 && (s2_ff.cmd == CMD_TICK) && s2_ff.wrap;

   stnl_history u_history (
      .clock    (clock),
      .reset    (reset),
      .shift_en (hist_shift),
      .mean_in  (s2_ff.mean),
      .hsum_now (hist_hsum)
   );

   assign s3_in.cmd         = s2_ff.cmd;
   assign s3_in.dark        = s2_ff.dark;
   assign s3_in.mean_scaled = CMP_W'(s2_ff.mean) * MEAN_GAIN;
   assign s3_in.hsum        = hist_hsum;

   always_ff @(posedge clock) begin
      if (mv2) begin
         s3_ff <= s3_in;
      end
   end

   // stage 4: lamp control and result register
   stnl_lamp_ctrl u_lamp_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load_en     (mv3),
      .item        (s3_ff),
      .on_duration (on_duration_ff),
      .lamp_drive  (rsp_lamp_drive),
      .lamp_is_on  (rsp_lamp_is_on),
      .lamp_select (rsp_lamp_select)
   );

endmodule

/* rtl/stnl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Night lamp checker
// Port-level assertions on the night lamp result channel, bound to the top
// level.
// ----------------------------------------------------------------------------
module stnl_checker
   import stnl_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [2:0]           rsp_lamp_drive,
   input logic                 rsp_lamp_is_on,
   input logic [2:0]           rsp_lamp_select
);

   // a stalled result stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lamp_drive)
         && $stable(rsp_lamp_is_on) && $stable(rsp_lamp_select))
      else $error("stalled result changed");

   // drive is the selection when lit, dark otherwise
   a_drive_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lamp_drive == (rsp_lamp_is_on ? rsp_lamp_select : 3'b000))
      else $error("lamp drive disagrees with state and selection");

   // only the three lamp-count masks can be reported
   a_select_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lamp_select == MASK_ALL) || (rsp_lamp_select == MASK_FIRST)
         || (rsp_lamp_select == MASK_SECOND))
      else $error("illegal lamp selection mask");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sound_triggered_night_lamp_unit stnl_checker u_stnl_checker (.*);

/* tb/night_lamp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Night lamp result checker
// Watches the item and result channels of the night lamp unit. It keeps its
// own copy of the window, history, lamp and register state. Each accepted
// item adds one expected result. Each accepted result is checked field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module night_lamp_checker
   import stnl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [13:0]          req_mic_sample,
   input  logic [15:0]          req_lux_level,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [2:0]           rsp_lamp_drive,
   input  logic                 rsp_lamp_is_on,
   input  logic [2:0]           rsp_lamp_select,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_write_data,
   output int                   lamp_fail_count,
   output int                   lamp_results_owed
);

   typedef struct packed {
      lamp_mask_type drive;
      logic          is_on;
      lamp_mask_type mask;
   } lamp_outputs_type;

   // register copies
   csr_data_type dark_level;
   csr_data_type on_hold_ticks;

   // lamp state copy
   sample_type       mic_window [WINDOW_DEPTH];
   int               window_slot;
   sample_type       second_means [HISTORY_DEPTH];
   logic             lamp_lit;
   logic [15:0]      ticks_to_off;
   lamp_count_type   lamps_in_use;
   lamp_outputs_type lamp_outputs_due [$];

   function automatic lamp_mask_type mask_for_count(input lamp_count_type n);
      lamp_mask_type m;
      if (n == LAMP_COUNT_TWO)
         m = MASK_FIRST;
      else if (n == LAMP_COUNT_ONE)
         m = MASK_SECOND;
      else
         m = MASK_ALL;
      return m;
   endfunction

   // steps the lamp state by one item and gives the outputs it reports
   task automatic advance_lamp_state(input cmd_type cmd, input sample_type mic,
                                     input logic [15:0] lux,
                                     output lamp_outputs_type res);
      int unsigned   window_total;
      int unsigned   history_total;
      int unsigned   window_mean;
      lamp_mask_type m;
      case (cmd)
         CMD_TICK: begin
            mic_window[window_slot] = mic;
            window_total = 0;
            foreach (mic_window[i]) window_total += mic_window[i];
            window_mean = window_total / WINDOW_DEPTH;
            // a full window pushes its mean into the history
            if (window_slot == WINDOW_DEPTH - 1) begin
               window_slot = 0;
               for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                  second_means[i] = second_means[i + 1];
               second_means[HISTORY_DEPTH - 1] = sample_type'(window_mean);
            end else begin
               window_slot++;
            end
            history_total = 0;
            foreach (second_means[i]) history_total += second_means[i];
            if (lamp_lit) begin
               // countdown to automatic switch-off
               if (ticks_to_off <= 16'd1) begin
                  lamp_lit     = 1'b0;
                  ticks_to_off = '0;
               end else begin
                  ticks_to_off = ticks_to_off - 16'd1;
               end
            end else if (lux < dark_level &&
                         window_mean * 10 * HISTORY_DEPTH > 11 * history_total) begin
               lamp_lit     = 1'b1;
               ticks_to_off = on_hold_ticks;
            end
         end
         CMD_POWER: begin
            if (lamp_lit) begin
               lamp_lit     = 1'b0;
               ticks_to_off = '0;
            end else begin
               lamp_lit     = 1'b1;
               ticks_to_off = on_hold_ticks;
            end
         end
         CMD_COUNT: begin
            lamps_in_use = (lamps_in_use >= LAMP_COUNT_ALL) ? LAMP_COUNT_ONE
                                                            : lamps_in_use + 2'd1;
         end
         default: ;
      endcase
      m         = mask_for_count(lamps_in_use);
      res.drive = lamp_lit ? m : '0;
      res.is_on = lamp_lit;
      res.mask  = m;
   endtask

   always @(posedge clock) begin
      lamp_outputs_type got;
      lamp_outputs_type want;
      lamp_outputs_type fresh;
      if (reset) begin
         dark_level    = DARK_THRESHOLD_RST;
         on_hold_ticks = ON_DURATION_RST;
         foreach (mic_window[i]) mic_window[i] = '0;
         foreach (second_means[i]) second_means[i] = '0;
         window_slot   = 0;
         lamp_lit      = 1'b0;
         ticks_to_off  = '0;
         lamps_in_use  = LAMP_COUNT_ALL;
         lamp_outputs_due.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == REG_DARK_THRESHOLD)
               dark_level = csr_write_data;
            else if (csr_index == REG_ON_DURATION)
               on_hold_ticks = csr_write_data;
         end
         // results first: a result never belongs to an item taken at this edge
         if (rsp_valid && !rsp_stall) begin
            got.drive = rsp_lamp_drive;
            got.is_on = rsp_lamp_is_on;
            got.mask  = rsp_lamp_select;
            if (lamp_outputs_due.size() == 0) begin
               $error("result item with no item outstanding: drive %0d on %0d select %0d",
                      got.drive, got.is_on, got.mask);
               lamp_fail_count++;
            end else begin
               want = lamp_outputs_due.pop_front();
               if (got.drive !== want.drive) begin
                  $error("lamp_drive: expected %0d, actual %0d", want.drive, got.drive);
                  lamp_fail_count++;
               end
               if (got.is_on !== want.is_on) begin
                  $error("lamp_is_on: expected %0d, actual %0d", want.is_on, got.is_on);
                  lamp_fail_count++;
               end
               if (got.mask !== want.mask) begin
                  $error("lamp_select: expected %0d, actual %0d", want.mask, got.mask);
                  lamp_fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_lamp_state(cmd_type'(req_cmd), req_mic_sample, req_lux_level, fresh);
            lamp_outputs_due.push_back(fresh);
         end
      end
      lamp_results_owed <= lamp_outputs_due.size();
   end

endmodule

/* tb/tb_sound_triggered_night_lamp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Night lamp unit testbench
// Drives button and sample items into the night lamp unit with random gaps
// and result back-pressure. It starts with a short directed run over the
// edge cases. Random runs follow, each under its own register setting. The
// checker beside the unit predicts and compares the results. This module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_sound_triggered_night_lamp_unit;
   import stnl_pkg::*;

   localparam int LONG_HOLD   = 80;
   localparam int QUIET_LIMIT = 1000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic [13:0]          req_mic_sample;
   logic [15:0]          req_lux_level;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_lamp_drive;
   logic                 rsp_lamp_is_on;
   logic [2:0]           rsp_lamp_select;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_write_data;

   int fail_count;
   int results_owed;
   int items_taken  = 0;
   int quiet_cycles = 0;
   bit calm           = 1'b0;
   bit long_hold_done = 1'b0;

   always #2 clock = ~clock;

   sound_triggered_night_lamp_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_mic_sample  (req_mic_sample),
      .req_lux_level   (req_lux_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lamp_drive  (rsp_lamp_drive),
      .rsp_lamp_is_on  (rsp_lamp_is_on),
      .rsp_lamp_select (rsp_lamp_select),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   night_lamp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_mic_sample    (req_mic_sample),
      .req_lux_level     (req_lux_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lamp_drive    (rsp_lamp_drive),
      .rsp_lamp_is_on    (rsp_lamp_is_on),
      .rsp_lamp_select   (rsp_lamp_select),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .lamp_fail_count   (fail_count),
      .lamp_results_owed (results_owed)
   );

   // watchdog on cycles with no handshake, plus the item count
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         items_taken <= items_taken + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold to fill the pipe
   initial begin : rsp_side
      rsp_stall <= 1'b0;
      wait (!reset);
      forever begin
         if (!long_hold_done && items_taken >= 300) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // offers one item, maybe after a gap, and holds it until taken
   task automatic send_item(input cmd_type cmd, input logic [13:0] mic,
                            input logic [15:0] lux);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_mic_sample <= mic;
      req_lux_level  <= lux;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // waits for every outstanding result, then lets the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_lamp_config(input csr_data_type thr, input csr_data_type dur);
      csr_write_en   <= 1'b1;
      csr_index      <= REG_DARK_THRESHOLD;
      csr_write_data <= thr;
      @(posedge clock);
      csr_index      <= REG_ON_DURATION;
      csr_write_data <= dur;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // random items: mostly quiet ticks with loud bursts, lux mostly below the threshold
   task automatic run_random_phase(input int n_items, input csr_data_type thr,
                                   input csr_data_type dur);
      int          taken;
      int          burst_left;
      int          pick;
      sample_type  quiet_base;
      sample_type  mic;
      logic [15:0] lux;
      cmd_type     cmd;
      set_lamp_config(thr, dur);
      quiet_base = sample_type'($urandom_range(0, 3000));
      taken      = 0;
      burst_left = 0;
      while (taken < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            cmd = CMD_TICK;
         else if (pick < 88)
            cmd = CMD_POWER;
         else if (pick < 96)
            cmd = CMD_COUNT;
         else
            cmd = CMD_IDLE;
         // a loud burst after a quiet stretch lifts the window over the history
         if (burst_left == 0 && $urandom_range(0, 24) == 0)
            burst_left = $urandom_range(3, 12);
         if (burst_left > 0) begin
            mic = sample_type'($urandom_range(6000, 16383));
            burst_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            mic = sample_type'($urandom);
         end else begin
            mic = quiet_base + sample_type'($urandom_range(0, 255));
         end
         if (thr != 0 && $urandom_range(0, 2) != 0)
            lux = 16'($urandom_range(0, thr - 1));
         else
            lux = 16'($urandom);
         send_item(cmd, mic, lux);
         taken++;
      end
      drain_results();
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_IDLE;
      req_mic_sample <= '0;
      req_lux_level  <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= REG_DARK_THRESHOLD;
      csr_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: lamp count cycle, ignored command, buttons
      send_item(CMD_COUNT, 14'd0, 16'd0);
      send_item(CMD_COUNT, 14'd0, 16'd0);
      send_item(CMD_COUNT, 14'd0, 16'd0);
      send_item(CMD_IDLE, 14'h3FFF, 16'hFFFF);
      send_item(CMD_POWER, 14'd0, 16'd0);
      send_item(CMD_COUNT, 14'd0, 16'd0);
      send_item(CMD_POWER, 14'd0, 16'd0);
      // loud tick in the dark over a silent history, then a countdown tick
      send_item(CMD_TICK, 14'h3FFF, 16'd0);
      send_item(CMD_TICK, 14'd0, 16'hFFFF);
      drain_results();

      // highest threshold, shortest on time; run the window over a wrap
      set_lamp_config(16'hFFFF, 16'd1);
      send_item(CMD_POWER, 14'd0, 16'd0);
      send_item(CMD_TICK, 14'h3FFF, 16'hFFFE);
      send_item(CMD_TICK, 14'd0, 16'd0);
      send_item(CMD_TICK, 14'h3FFF, 16'hFFFF);
      repeat (5) send_item(CMD_TICK, 14'h3FFF, 16'd0);
      drain_results();

      // zero threshold is never dark; zero on time behaves as one tick
      set_lamp_config(16'd0, 16'd0);
      send_item(CMD_POWER, 14'd0, 16'd0);
      send_item(CMD_TICK, 14'h3FFF, 16'd0);
      send_item(CMD_TICK, 14'h3FFF, 16'd0);
      drain_results();

      // longest on time, count change while lit
      set_lamp_config(16'hFFFF, 16'hFFFF);
      send_item(CMD_POWER, 14'd0, 16'd0);
      send_item(CMD_TICK, 14'h1555, 16'h5555);
      send_item(CMD_COUNT, 14'd0, 16'd0);
      send_item(CMD_POWER, 14'd0, 16'd0);
      drain_results();

      run_random_phase(200, DARK_THRESHOLD_RST, ON_DURATION_RST);
      run_random_phase(120, 16'd0, 16'd1);
      run_random_phase(120, 16'hFFFF, 16'hFFFF);
      run_random_phase(200, csr_data_type'($urandom_range(0, 65535)),
                       csr_data_type'($urandom_range(1, 64)));
      run_random_phase(120, 16'd40000, 16'd0);
      calm = 1'b1;
      run_random_phase(270, 16'd1000, 16'd5);

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
